// ----- rtl/core/bilinear_texture_sampler_top_macros.svh -----
// Assertion macros used by the port checker of the bilinear texture sampler.
`ifndef BILINEAR_TEXTURE_SAMPLER_TOP_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define BTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bilinear texture sampler port check failed");

// Next-cycle implication, checked while out of reset.
`define BTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bilinear texture sampler port check failed");

`endif

// ----- rtl/core/bts_pkg.sv -----
// Types and constants shared by the bilinear texture sampler modules.
package bts_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_W    = 16;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int TEXEL_W   = CH_W * NUM_CH;
  localparam int OUT_W     = 16;
  localparam int ROW_W     = CH_W + FRAC_W;
  localparam int SUM_W     = CH_W + 2 * FRAC_W;

  localparam logic [FRAC_W-1:0] HALF_TEXEL = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH  = 1'b0,
    CFG_TEX_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  // Order of the four texel reads of one sample
  typedef enum logic [1:0] {
    PH_T00 = 2'd0,
    PH_T10 = 2'd1,
    PH_T01 = 2'd2,
    PH_T11 = 2'd3
  } phase_t;

  typedef struct packed {
    func_t              func;
    logic [7:0]         texel_x;
    logic [7:0]         texel_y;
    logic [TEXEL_W-1:0] texel_rgba;
    logic [FRAC_W-1:0]  u_frac;
    logic [FRAC_W-1:0]  v_frac;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] alpha;
  } out_item_t;

  // Travels with each texel read, in the cycle before its read data
  typedef struct packed {
    logic              valid;
    phase_t            phase;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } fetch_tag_t;

endpackage

// ----- rtl/core/bts_texel_mem.sv -----
// Single-port texel memory with registered read data.
module bts_texel_mem #(
  parameter int MAX_SIDE = 256
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        we,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] addr,
  input  logic [bts_pkg::TEXEL_W-1:0] wdata,
  output logic [bts_pkg::TEXEL_W-1:0] rdata
);
  import bts_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  logic [TEXEL_W-1:0] mem [DEPTH];
  logic [TEXEL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/bts_fetch_seq.sv -----
// Input stage, axis decode and texel memory sequencer.
module bts_fetch_seq #(
  parameter int MAX_SIDE = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  bts_pkg::in_item_t     in_item,
  input  logic [$clog2(((MAX_SIDE < 511) ? MAX_SIDE : 511)+1)-1:0] side_w,
  input  logic [$clog2(((MAX_SIDE < 511) ? MAX_SIDE : 511)+1)-1:0] side_h,
  output logic                  busy,
  output logic                  mem_en,
  output logic                  mem_we,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] mem_addr,
  output logic [bts_pkg::TEXEL_W-1:0] mem_wdata,
  output bts_pkg::fetch_tag_t   tag
);
  import bts_pkg::*;

  localparam int SIDE_EFF = (MAX_SIDE < 511) ? MAX_SIDE : 511;
  localparam int SIDE_W   = $clog2(SIDE_EFF + 1);
  localparam int IDX_W    = $clog2(SIDE_EFF);
  localparam int ADDR_W   = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int P_W      = FRAC_W + SIDE_W;

  // Stage A: accepted item with coordinate products
  logic               a_valid_r, a_valid_nxt;
  func_t              a_func_r;
  logic               a_one_r;
  logic [P_W-1:0]     a_pu_r, a_pv_r;
  logic               a_wr_ok_r;
  logic [ADDR_W-1:0]  a_wr_addr_r;
  logic [TEXEL_W-1:0] a_rgba_r;

  // Sequencer: owns the memory port
  logic               s_valid_r, s_valid_nxt;
  phase_t             s_cnt_r, s_cnt_nxt;
  func_t              s_func_r;
  logic [IDX_W-1:0]   s_x0_r, s_x1_r, s_y0_r, s_y1_r;
  logic [FRAC_W-1:0]  s_fx_r, s_fy_r;
  logic               s_wr_ok_r;
  logic [ADDR_W-1:0]  s_wr_addr_r;
  logic [TEXEL_W-1:0] s_rgba_r;

  logic               accept, s_done, s_load, a_move;
  logic [IDX_W-1:0]   x0, x1, y0, y1, rd_x, rd_y;
  logic [FRAC_W-1:0]  fx, fy;
  logic [P_W-1:0]     pu_m, pv_m;

  assign s_done = s_valid_r && ((s_func_r == FUNC_WRITE) || (s_cnt_r == PH_T11));
  assign s_load = !s_valid_r || s_done;
  assign a_move = a_valid_r && s_load;
  assign busy   = a_valid_r && !s_load;
  assign accept = start && !busy;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
    s_valid_nxt = s_valid_r;
    s_cnt_nxt   = s_cnt_r;
    if (a_move) begin
      s_valid_nxt = 1'b1;
      s_cnt_nxt   = PH_T00;
    end else if (s_done) begin
      s_valid_nxt = 1'b0;
    end else if (s_valid_r) begin
      s_cnt_nxt = phase_t'(s_cnt_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      s_cnt_r   <= PH_T00;
    end else begin
      a_valid_r <= a_valid_nxt;
      s_valid_r <= s_valid_nxt;
      s_cnt_r   <= s_cnt_nxt;
    end
  end

  // Position times side, taken straight off the input
  always_ff @(posedge clk) begin
    if (accept) begin
      a_func_r    <= in_item.func;
      a_one_r     <= (side_w == SIDE_W'(1)) || (side_h == SIDE_W'(1));
      a_pu_r      <= P_W'(in_item.u_frac) * P_W'(side_w);
      a_pv_r      <= P_W'(in_item.v_frac) * P_W'(side_h);
      a_wr_ok_r   <= (32'(in_item.texel_x) < MAX_SIDE) && (32'(in_item.texel_y) < MAX_SIDE);
      a_wr_addr_r <= ADDR_W'(32'(in_item.texel_y) * MAX_SIDE + 32'(in_item.texel_x));
      a_rgba_r    <= in_item.texel_rgba;
    end
  end

  // Half-texel shift and wrap; below zero wraps to the last texel
  always_comb begin
    pu_m = a_pu_r - P_W'(HALF_TEXEL);
    pv_m = a_pv_r - P_W'(HALF_TEXEL);
    if (a_pu_r < P_W'(HALF_TEXEL)) begin
      x0 = IDX_W'(side_w - SIDE_W'(1));
    end else begin
      x0 = pu_m[IDX_W+FRAC_W-1:FRAC_W];
    end
    if (a_pv_r < P_W'(HALF_TEXEL)) begin
      y0 = IDX_W'(side_h - SIDE_W'(1));
    end else begin
      y0 = pv_m[IDX_W+FRAC_W-1:FRAC_W];
    end
    x1 = (x0 == IDX_W'(side_w - SIDE_W'(1))) ? '0 : x0 + IDX_W'(1);
    y1 = (y0 == IDX_W'(side_h - SIDE_W'(1))) ? '0 : y0 + IDX_W'(1);
    fx = a_pu_r[FRAC_W-1:0] ^ HALF_TEXEL;
    fy = a_pv_r[FRAC_W-1:0] ^ HALF_TEXEL;
    // side of one: four reads of texel (0,0) at zero weight
    if (a_one_r) begin
      x0 = '0;
      x1 = '0;
      y0 = '0;
      y1 = '0;
      fx = '0;
      fy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      s_func_r    <= a_func_r;
      s_x0_r      <= x0;
      s_x1_r      <= x1;
      s_y0_r      <= y0;
      s_y1_r      <= y1;
      s_fx_r      <= fx;
      s_fy_r      <= fy;
      s_wr_ok_r   <= a_wr_ok_r;
      s_wr_addr_r <= a_wr_addr_r;
      s_rgba_r    <= a_rgba_r;
    end
  end

  always_comb begin
    case (s_cnt_r)
      PH_T00: begin
        rd_x = s_x0_r;
        rd_y = s_y0_r;
      end
      PH_T10: begin
        rd_x = s_x1_r;
        rd_y = s_y0_r;
      end
      PH_T01: begin
        rd_x = s_x0_r;
        rd_y = s_y1_r;
      end
      default: begin
        rd_x = s_x1_r;
        rd_y = s_y1_r;
      end
    endcase
  end

  assign mem_en    = s_valid_r && ((s_func_r == FUNC_SAMPLE) || s_wr_ok_r);
  assign mem_we    = s_valid_r && (s_func_r == FUNC_WRITE);
  assign mem_addr  = (s_func_r == FUNC_WRITE) ? s_wr_addr_r
                     : ADDR_W'(32'(rd_y) * MAX_SIDE + 32'(rd_x));
  assign mem_wdata = s_rgba_r;

  assign tag.valid = s_valid_r && (s_func_r == FUNC_SAMPLE);
  assign tag.phase = s_cnt_r;
  assign tag.fx    = s_fx_r;
  assign tag.fy    = s_fy_r;

endmodule

// ----- rtl/core/bts_blend.sv -----
// Bilinear blend pipeline: row blends, column blend, rounding, result register.
module bts_blend (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bts_pkg::fetch_tag_t         tag,
  input  logic [bts_pkg::TEXEL_W-1:0] rd_data,
  output logic                        out_valid,
  output bts_pkg::out_item_t          out_item
);
  import bts_pkg::*;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SUM_W - OUT_W - 1);

  fetch_tag_t         tag_r;
  logic [TEXEL_W-1:0] t_lo_r;
  logic [ROW_W-1:0]   h0_r [NUM_CH];
  logic [ROW_W-1:0]   h1_r [NUM_CH];
  logic [FRAC_W-1:0]  fy_r;
  logic               col_valid_r;
  logic [SUM_W-1:0]   sum_r [NUM_CH];
  logic               sum_valid_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [ROW_W-1:0]   hrow [NUM_CH];
  logic [SUM_W-1:0]   col  [NUM_CH];
  logic [OUT_W-1:0]   chan [NUM_CH];

  // lo*(1-f) + hi*f written as lo + (hi-lo)*f
  always_comb begin
    logic signed [CH_W:0]         d;
    logic signed [CH_W+FRAC_W+1:0] p;
    logic signed [ROW_W:0]        dv;
    logic signed [SUM_W+1:0]      pc;
    logic [SUM_W-1:0]             r;
    for (int c = 0; c < NUM_CH; c++) begin
      d = $signed({1'b0, rd_data[CH_W*c +: CH_W]}) - $signed({1'b0, t_lo_r[CH_W*c +: CH_W]});
      p = d * $signed({1'b0, tag_r.fx});
      p = p + $signed({2'b0, t_lo_r[CH_W*c +: CH_W], {FRAC_W{1'b0}}});
      hrow[c] = p[ROW_W-1:0];
      dv = $signed({1'b0, h1_r[c]}) - $signed({1'b0, h0_r[c]});
      pc = dv * $signed({1'b0, fy_r});
      pc = pc + $signed({2'b0, h0_r[c], {FRAC_W{1'b0}}});
      col[c] = pc[SUM_W-1:0];
      r = sum_r[c] + ROUND_HALF;
      chan[c] = r[SUM_W-1:SUM_W-OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= '0;
      col_valid_r <= 1'b0;
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tag_r       <= tag;
      col_valid_r <= tag_r.valid && (tag_r.phase == PH_T11);
      sum_valid_r <= col_valid_r;
      out_valid_r <= sum_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_r.valid) begin
      case (tag_r.phase)
        PH_T00, PH_T01: begin
          t_lo_r <= rd_data;
        end
        PH_T10: begin
          h0_r <= hrow;
        end
        default: begin
          h1_r <= hrow;
          fy_r <= tag_r.fy;
        end
      endcase
    end
    if (col_valid_r) begin
      sum_r <= col;
    end
    if (sum_valid_r) begin
      out_item_r.red   <= chan[0];
      out_item_r.green <= chan[1];
      out_item_r.blue  <= chan[2];
      out_item_r.alpha <= chan[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/bilinear_texture_sampler_top.sv -----
// Top level of the bilinear texture sampler with wrap addressing.
//
// Holds an RGBA8 texture of up to MAX_SIDE x MAX_SIDE texels in one single-port
// memory and filters it bilinearly with wrap addressing. An item is taken when
// start is high and busy is low. A write item (func 0) takes one access of the
// memory port and gives no result; a write outside the store is dropped. A
// sample item (func 1) takes four accesses of the memory port, one per texel
// read; writes run at one item a cycle while no sample holds the port. The next
// item is taken into an input stage while the current one is still reading. A
// sample moves on to the sequencer once the memory port is free, and its
// result is registered in the row blends, the column blend and the result
// register. Results leave in item order. Each result is shown on out_item for
// exactly one cycle with out_valid high: the receiver cannot stall, so it must
// take every result as it comes. Channels are byte scale with 8 fraction bits,
// rounded half up. If either side is 1 the result is texel (0,0) scaled by 256.
// The texel store has no reset and no clearing pass: sample only texels that
// have been written. tex_width (index 0) and tex_height (index 1) reset to 1; a
// 0 is taken as 1 and a value above MAX_SIDE as MAX_SIDE. Write them only while
// the block is idle.
module bilinear_texture_sampler_top #(
  parameter int MAX_SIDE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bts_pkg::in_item_t             in_item,
  output logic                          out_valid,
  output bts_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]     cfg_wdata
);
  import bts_pkg::*;

  localparam int SIDE_EFF = (MAX_SIDE < 511) ? MAX_SIDE : 511;
  localparam int SIDE_W   = $clog2(SIDE_EFF + 1);
  localparam int ADDR_W   = $clog2(MAX_SIDE * MAX_SIDE);

  // Sides are held already clamped to the range in use
  logic [SIDE_W-1:0]  tex_w_r, tex_w_nxt;
  logic [SIDE_W-1:0]  tex_h_r, tex_h_nxt;
  logic [SIDE_W-1:0]  side_in;

  logic               mem_en, mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [TEXEL_W-1:0] mem_wdata, mem_rdata;
  fetch_tag_t         tag;

  always_comb begin
    if (cfg_wdata == '0) begin
      side_in = SIDE_W'(1);
    end else if (32'(cfg_wdata) > MAX_SIDE) begin
      side_in = SIDE_W'(MAX_SIDE);
    end else begin
      side_in = SIDE_W'(cfg_wdata);
    end
    tex_w_nxt = tex_w_r;
    tex_h_nxt = tex_h_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEX_WIDTH:  tex_w_nxt = side_in;
        CFG_TEX_HEIGHT: tex_h_nxt = side_in;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= SIDE_W'(1);
      tex_h_r <= SIDE_W'(1);
    end else begin
      tex_w_r <= tex_w_nxt;
      tex_h_r <= tex_h_nxt;
    end
  end

  // Input stage and memory port sequencer
  bts_fetch_seq #(
    .MAX_SIDE (MAX_SIDE)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .side_w    (tex_w_r),
    .side_h    (tex_h_r),
    .busy      (busy),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .tag       (tag)
  );

  // Texel store, one access per cycle
  bts_texel_mem #(
    .MAX_SIDE (MAX_SIDE)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Weighting and result register
  bts_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag),
    .rd_data   (mem_rdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/core/bts_port_checker.sv -----
// Port-level checks of the bilinear texture sampler and their bind.
`include "bilinear_texture_sampler_top_macros.svh"

module bts_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input bts_pkg::out_item_t            out_item
);
  import bts_pkg::*;

  localparam logic [OUT_W-1:0] CH_MAX = 16'hFF00;

  // no stale strobe straight out of reset
  `BTS_ASSERT_IMP(a_reset_quiet, clk, rst_n, $past(!rst_n), !out_valid)

  // busy only ever follows a taken item
  `BTS_ASSERT_IMP(a_busy_cause, clk, rst_n, busy, $past(busy) || $past(start && !busy))

  // blend weights sum to one, so no channel exceeds full byte scale
  `BTS_ASSERT_IMP(a_chan_range, clk, rst_n, out_valid,
    (out_item.red <= CH_MAX) && (out_item.green <= CH_MAX) &&
    (out_item.blue <= CH_MAX) && (out_item.alpha <= CH_MAX))

  // four memory reads per sample keep results spaced apart
  `BTS_ASSERT_NXT(a_gap_next, clk, rst_n, out_valid, !out_valid)
  `BTS_ASSERT_IMP(a_gap_far, clk, rst_n, out_valid, !$past(out_valid, 2) && !$past(out_valid, 3))

endmodule

bind bilinear_texture_sampler_top bts_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- bench/tb_bilinear_texture_sampler_top.sv -----
// Self-checking bench for the bilinear texture sampler: texel loads, wrap filtering, side registers.
module tb_bilinear_texture_sampler_top;
  import bts_pkg::*;

  localparam int MAX_SIDE     = 256;
  localparam int CYCLE_LIMIT  = 400000;
  // Writes give nothing back to wait on, so once the last owed result is in,
  // this many quiet cycles are allowed before any register write or the end.
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET  = 1850;
  localparam int STREAM_ITEMS = 300;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bilinear_texture_sampler_top #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow of the texture and the side registers, updated in item order
  bit [TEXEL_W-1:0] texel_shadow [MAX_SIDE*MAX_SIDE];
  bit               texel_loaded [MAX_SIDE*MAX_SIDE];
  bit [CFG_W-1:0]   width_reg  = 1;
  bit [CFG_W-1:0]   height_reg = 1;

  out_item_t colour_queue[$];  // filtered colours still owed by the block
  int        error_count = 0;
  int        items_sent  = 0;
  int        cycle_count = 0;
  int        idle_odds   = 4;  // 1-in-N chance of a gap before an item, 0 for none

  // ---------------------------------------------------------------------------
  // Filter arithmetic
  // ---------------------------------------------------------------------------

  // Register value as the block uses it: 0 reads as 1, above MAX_SIDE clamps
  function automatic int unsigned side_used(bit [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_SIDE) return MAX_SIDE;
    return r;
  endfunction

  // Position = frac*side - half texel, biased by one whole side to stay positive.
  // Gives the lower and upper texel along the axis and the upper texel's weight.
  function automatic void axis_split(input bit [FRAC_W-1:0] frac, input int unsigned side,
                                     output int unsigned lo, output int unsigned hi,
                                     output bit [FRAC_W-1:0] wt);
    bit [63:0] q;
    q  = 64'(frac) * 64'(side) + (64'(side) << 16) - 64'd32768;
    lo = 32'((q >> 16) % 64'(side));
    hi = (lo + 1) % side;
    wt = q[FRAC_W-1:0];
  endfunction

  function automatic out_item_t filter_sample(in_item_t it);
    int unsigned      w, h;
    int unsigned      xs[2], ys[2];
    bit [FRAC_W-1:0]  fx, fy;
    bit [63:0]        wx[2], wy[2];
    bit [63:0]        sum;
    bit [TEXEL_W-1:0] t;
    out_item_t        res;
    w = side_used(width_reg);
    h = side_used(height_reg);
    res = '0;
    // Degenerate texture: texel (0,0) straight through, scaled to 8.8
    if (w == 1 || h == 1) begin
      t = texel_shadow[0];
      for (int c = 0; c < NUM_CH; c++)
        res[(NUM_CH-1-c)*OUT_W +: OUT_W] = {t[c*CH_W +: CH_W], 8'h00};
      return res;
    end
    axis_split(it.u_frac, w, xs[0], xs[1], fx);
    axis_split(it.v_frac, h, ys[0], ys[1], fy);
    wx[1] = 64'(fx);
    wx[0] = 64'd65536 - 64'(fx);
    wy[1] = 64'(fy);
    wy[0] = 64'd65536 - 64'(fy);
    for (int c = 0; c < NUM_CH; c++) begin
      sum = 0;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) begin
          t = texel_shadow[ys[j]*MAX_SIDE + xs[i]];
          sum += 64'(t[c*CH_W +: CH_W]) * wx[i] * wy[j];
        end
      // Sum is in units of 2^-32; round half up to 8 fraction bits
      res[(NUM_CH-1-c)*OUT_W +: OUT_W] = 16'((sum + 64'h80_0000) >> 24);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item driving
  // ---------------------------------------------------------------------------

  // Every path out of here leaves start to the next drive_item or to wait_idle,
  // both of which assign it in the same step, so start is never left high with
  // a stale item behind it.
  task automatic drive_item(in_item_t it);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Taken at this edge
    items_sent++;
    if (it.func == FUNC_WRITE) begin
      texel_shadow[it.texel_y*MAX_SIDE + it.texel_x] = it.texel_rgba;
      texel_loaded[it.texel_y*MAX_SIDE + it.texel_x] = 1'b1;
    end else begin
      colour_queue.push_back(filter_sample(it));
    end
  endtask

  // Don't-care fields of both kinds of item carry random noise
  function automatic in_item_t noise_item();
    in_item_t it;
    it.func       = FUNC_WRITE;
    it.texel_x    = 8'($urandom_range(0, 255));
    it.texel_y    = 8'($urandom_range(0, 255));
    it.texel_rgba = $urandom;
    it.u_frac     = 16'($urandom_range(0, 65535));
    it.v_frac     = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic write_texel(int unsigned x, int unsigned y, bit [TEXEL_W-1:0] rgba);
    in_item_t it;
    it            = noise_item();
    it.func       = FUNC_WRITE;
    it.texel_x    = 8'(x);
    it.texel_y    = 8'(y);
    it.texel_rgba = rgba;
    drive_item(it);
  endtask

  // Store has no reset: any of the four texels not yet loaded gets a random
  // texel first, so no sample ever reads an unwritten entry.
  task automatic sample_at(bit [FRAC_W-1:0] u, bit [FRAC_W-1:0] v);
    in_item_t        it;
    int unsigned     xs[2], ys[2];
    bit [FRAC_W-1:0] wt;
    axis_split(u, side_used(width_reg), xs[0], xs[1], wt);
    axis_split(v, side_used(height_reg), ys[0], ys[1], wt);
    if (side_used(width_reg) == 1 || side_used(height_reg) == 1) begin
      xs = '{0, 0};
      ys = '{0, 0};
    end
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (!texel_loaded[ys[j]*MAX_SIDE + xs[i]])
          write_texel(xs[i], ys[j], $urandom);
    it        = noise_item();
    it.func   = FUNC_SAMPLE;
    it.u_frac = u;
    it.v_frac = v;
    drive_item(it);
  endtask

  // Stop sending, let every owed colour arrive, then let queued writes settle
  task automatic wait_idle();
    start <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic set_sides(bit [CFG_W-1:0] w, bit [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TEX_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    width_reg = w;
    cfg_index <= CFG_TEX_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    height_reg = h;
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------

  // Register values at the edges, including ones the block must clamp
  function automatic bit [CFG_W-1:0] edge_side();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 255;
      4:       return 256;
      5:       return 257;
      6:       return 511;
      default: return CFG_W'($urandom_range(1, 511));
    endcase
  endfunction

  // Mostly random, now and then right on a texel boundary or the wrap point
  function automatic bit [FRAC_W-1:0] pick_coord();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // A quarter writes (half inside the texture in use, half anywhere), the rest samples
  task automatic run_mixed(int n);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:
          write_texel($urandom_range(0, side_used(width_reg) - 1),
                      $urandom_range(0, side_used(height_reg) - 1), $urandom);
        1:
          write_texel($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
        default:
          sample_at(pick_coord(), pick_coord());
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset sides are 1x1, then a side of 1 on one axis only, then a 0 read as 1
  task automatic test_unit_side();
    write_texel(0, 0, 32'hFFFF_FFFF);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'hFFFF, 16'hFFFF);
    write_texel(0, 0, 32'h8040_2001);
    sample_at(16'h8000, 16'h1234);
    wait_idle();
    set_sides(1, 7);
    sample_at(16'hFFFF, 16'h0000);
    wait_idle();
    set_sides(9, 1);
    sample_at(16'h0000, 16'hFFFF);
    wait_idle();
    set_sides(0, 0);
    sample_at(16'h7FFF, 16'h7FFF);
  endtask

  // A 2x3 texture, chequered with black and white, sampled at and just either
  // side of the wrap point, and at and just below the middle
  task automatic test_coordinate_extremes();
    bit [FRAC_W-1:0] coords[5];
    coords = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
    wait_idle();
    set_sides(2, 3);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 2; x++)
        write_texel(x, y, ((x + y) % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
    for (int i = 0; i < 5; i++)
      sample_at(coords[i], coords[4-i]);
  endtask

  // Register values above MAX_SIDE clamp to the full texture
  task automatic test_side_clamp();
    wait_idle();
    set_sides(511, 257);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'hFFFF, 16'h8000);
    wait_idle();
    set_sides(256, 255);
    sample_at(16'h7FFF, 16'hFFFF);
  endtask

  // Phases of random texture sizes and gap rates; small sizes dominate
  task automatic test_random_sampling();
    bit [CFG_W-1:0] w, h;
    while (items_sent < ITEM_TARGET - STREAM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        w = CFG_W'($urandom_range(2, 24));
        h = CFG_W'($urandom_range(2, 24));
      end else begin
        w = edge_side();
        h = edge_side();
      end
      wait_idle();
      set_sides(w, h);
      case ($urandom_range(0, 3))
        0:       idle_odds = 0;
        1:       idle_odds = 2;
        2:       idle_odds = 4;
        default: idle_odds = 8;
      endcase
      run_mixed($urandom_range(40, 160));
    end
  endtask

  // Last stretch back to back, no gaps at all
  task automatic test_back_to_back();
    wait_idle();
    set_sides(CFG_W'($urandom_range(3, 17)), CFG_W'($urandom_range(3, 17)));
    idle_odds = 0;
    run_mixed(STREAM_ITEMS);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every strobed result is matched with the oldest colour owed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_colour
    out_item_t want;
    string     chan_name[NUM_CH];
    chan_name = '{"red", "green", "blue", "alpha"};
    if (rst_n && out_valid) begin
      if (colour_queue.size() == 0) begin
        $display("%0t: result with none owed: expected nothing, got %h", $time, out_item);
        error_count++;
      end else begin
        want = colour_queue.pop_front();
        for (int c = 0; c < NUM_CH; c++)
          if (want[(NUM_CH-1-c)*OUT_W +: OUT_W] != out_item[(NUM_CH-1-c)*OUT_W +: OUT_W]) begin
            $display("%0t: %s expected %h got %h", $time, chan_name[c],
                     want[(NUM_CH-1-c)*OUT_W +: OUT_W], out_item[(NUM_CH-1-c)*OUT_W +: OUT_W]);
            error_count++;
          end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still owed", $time, colour_queue.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_TEX_WIDTH;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unit_side();
    test_coordinate_extremes();
    test_side_clamp();
    test_random_sampling();
    test_back_to_back();
    wait_idle();

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bts_pkg.sv
rtl/core/bts_texel_mem.sv
rtl/core/bts_fetch_seq.sv
rtl/core/bts_blend.sv
rtl/core/bilinear_texture_sampler_top.sv
rtl/core/bts_port_checker.sv
bench/tb_bilinear_texture_sampler_top.sv
